>>> rtl/core/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, fixed-point constants and helpers shared by the DH kinematics block.
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int ITER_W = 5;

	typedef logic signed [17:0] rot_t;
	typedef logic signed [31:0] q16_t;
	typedef logic signed [32:0] ext_t;
	typedef logic signed [50:0] prod_t;
	typedef logic signed [52:0] acc_t;

	localparam rot_t ONE_Q16 = 18'sd65536;
	localparam rot_t ROT_MAX = 18'sd131071;
	localparam rot_t ROT_MIN = -18'sd131072;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032875;

	// arctan(2^-i), 2^32 per turn
	localparam logic [63:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
		64'd536870912, 64'd316933406, 64'd167458907, 64'd85004756,
		64'd42667331, 64'd21354465, 64'd10679838, 64'd5340245,
		64'd2670163, 64'd1335087, 64'd667544, 64'd333772,
		64'd166886, 64'd83443, 64'd41722, 64'd20861,
		64'd10430, 64'd5215, 64'd2608, 64'd1304,
		64'd652, 64'd326, 64'd163, 64'd81
	};

	// round half up by 16 bits
	function automatic logic signed [36:0] rnd16(input acc_t v);
		acc_t t;
		begin
			t = v + 53'sd32768;
			rnd16 = 37'(t >>> 16);
		end
	endfunction

	function automatic rot_t sat18(input logic signed [37:0] v);
		begin
			if (v > 38'sd131071) sat18 = ROT_MAX;
			else if (v < -38'sd131072) sat18 = ROT_MIN;
			else sat18 = v[17:0];
		end
	endfunction

	function automatic q16_t sat32(input logic signed [37:0] v);
		begin
			if (v > 38'sd2147483647) sat32 = 32'sh7FFFFFFF;
			else if (v < -38'sd2147483648) sat32 = 32'sh80000000;
			else sat32 = v[31:0];
		end
	endfunction

endpackage

>>> rtl/core/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q.16 cos/sin.
// ----------------------------------------------------------------------------
module dhfk_cordic #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [15:0] angle,
	output logic done,
	output dhfk_pkg::rot_t cos_o,
	output dhfk_pkg::rot_t sin_o
);
	import dhfk_pkg::*;

	localparam int ZW = ANGLE_BITS + 2;
	localparam logic [ITER_W-1:0] LAST_I = ITER_W'(CORDIC_ITERATIONS - 1);

	logic busy_q, done_q, neg_q;
	logic [ITER_W-1:0] i_q;
	logic signed [32:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	logic [ANGLE_BITS+15:0] scl_w;
	logic signed [ZW-1:0] z0_w, zf_w, quarter_w, half_w, step_w;
	logic neg0_w;
	logic [63:0] step64_w;
	logic signed [34:0] xn_w, yn_w, xr_w, yr_w;

	always_comb begin
		scl_w = {angle, ANGLE_BITS'(0)};
		z0_w = ZW'($signed(scl_w[ANGLE_BITS+15:16]));
		quarter_w = ZW'(1) <<< (ANGLE_BITS - 2);
		half_w = ZW'(1) <<< (ANGLE_BITS - 1);
		// fold into plus/minus a quarter turn
		zf_w = z0_w;
		neg0_w = 1'b0;
		if (z0_w > quarter_w) begin
			zf_w = z0_w - half_w;
			neg0_w = 1'b1;
		end else if (z0_w < -quarter_w) begin
			zf_w = z0_w + half_w;
			neg0_w = 1'b1;
		end
		step64_w = (ATAN_TURN32[i_q] + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
		step_w = ZW'(step64_w[ANGLE_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == LAST_I) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= zf_w;
			neg_q <= neg0_w;
			i_q <= '0;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - step_w;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + step_w;
			end
			i_q <= i_q + ITER_W'(1);
		end
	end

	always_comb begin
		xn_w = neg_q ? -35'(x_q) : 35'(x_q);
		yn_w = neg_q ? -35'(y_q) : 35'(y_q);
		xr_w = (xn_w + 35'sd8192) >>> 14;
		yr_w = (yn_w + 35'sd8192) >>> 14;
		if (xr_w > 35'sd65536) cos_o = ONE_Q16;
		else if (xr_w < -35'sd65536) cos_o = -ONE_Q16;
		else cos_o = xr_w[17:0];
		if (yr_w > 35'sd65536) sin_o = ONE_Q16;
		else if (yr_w < -35'sd65536) sin_o = -ONE_Q16;
		else sin_o = yr_w[17:0];
	end

	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("cordic done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("cordic did not start");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("cordic restarted while busy");

endmodule

>>> rtl/core/dh_forward_kinematics_chain.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg forward kinematics, one joint per item, frame out as rows.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | joint value, a, alpha, d, theta, flags
//  out     | output    | out_valid/out_ready | row index, 3 rotation cols, translation
//
// Each joint is accepted, runs the CORDIC on theta and then on alpha, forms the
// link products and then the 3x4 product, and leaves as three rows; the shared
// 18x33 multiplier runs one multiply, then one accumulate.
// Reset loads the identity frame. in_ready is high only when idle; the three
// rows wait in the output register for out_ready, and the next joint is
// taken after row 2 leaves.
module dh_forward_kinematics_chain #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] joint_value,
	input  logic signed [31:0] link_length_a,
	input  logic [15:0] link_twist_alpha,
	input  logic signed [31:0] link_offset_d,
	input  logic [15:0] link_angle_theta,
	input  logic is_prismatic,
	input  logic last_joint,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] row_index,
	output logic signed [17:0] rot_col0,
	output logic signed [17:0] rot_col1,
	output logic signed [17:0] rot_col2,
	output logic signed [31:0] translation,
	output logic last_row,
	output logic end_of_chain
);
	import dhfk_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CORT = 8'b0000_0010,
		ST_CORA = 8'b0000_0100,
		ST_LMUL = 8'b0000_1000,
		ST_LACC = 8'b0001_0000,
		ST_MMUL = 8'b0010_0000,
		ST_MACC = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic start_q, last_q;
	q16_t a_q, d_q;
	logic [15:0] alpha_q, theta_q;
	rot_t ct_q, st_q, ca_q, sa_q;
	rot_t rel1_q, rel2_q, rel4_q, rel5_q;
	ext_t p0_q, p1_q;
	rot_t rr_q [9];
	q16_t rt_q [3];
	rot_t nr_q [9];
	q16_t nt_q [3];
	prod_t prod_q;
	acc_t acc_q;
	logic [2:0] op_q;
	logic [1:0] r_q, c_q, k_q, row_q;

	logic cor_done;
	rot_t cor_cos, cor_sin;
	logic signed [32:0] dsum_w;
	rot_t rel_w [9];
	rot_t opa_w;
	ext_t opb_w;
	acc_t acc_w;
	logic signed [36:0] rnd_w;
	logic [3:0] ra_w, rb_w, ro_w;

	dhfk_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.angle((state_q == ST_CORT) ? theta_q : alpha_q),
		.done(cor_done),
		.cos_o(cor_cos),
		.sin_o(cor_sin)
	);

	// link transform, column 3 is p
	always_comb begin
		rel_w[0] = ct_q;   rel_w[1] = rel1_q; rel_w[2] = rel2_q;
		rel_w[3] = st_q;   rel_w[4] = rel4_q; rel_w[5] = rel5_q;
		rel_w[6] = '0;     rel_w[7] = sa_q;   rel_w[8] = ca_q;
		ra_w = 4'(r_q) * 4'd3 + 4'(k_q);
		rb_w = 4'(k_q) * 4'd3 + 4'(c_q);
		ro_w = 4'(r_q) * 4'd3 + 4'(c_q);
		opa_w = rr_q[ra_w];
		opb_w = 33'(rel_w[rb_w]);
		if (state_q == ST_LMUL) begin
			case (op_q)
				3'd0: begin opa_w = st_q; opb_w = 33'(ca_q); end
				3'd1: begin opa_w = st_q; opb_w = 33'(sa_q); end
				3'd2: begin opa_w = ct_q; opb_w = 33'(ca_q); end
				3'd3: begin opa_w = ct_q; opb_w = 33'(sa_q); end
				3'd4: begin opa_w = ct_q; opb_w = 33'(a_q); end
				default: begin opa_w = st_q; opb_w = 33'(a_q); end
			endcase
		end else if (c_q == 2'd3) begin
			case (k_q)
				2'd0: opb_w = p0_q;
				2'd1: opb_w = p1_q;
				default: opb_w = 33'(d_q);
			endcase
		end
		acc_w = ((state_q == ST_MACC && k_q != 2'd0) ? acc_q : '0) + 53'(prod_q);
		rnd_w = rnd16(acc_w);
		dsum_w = 33'(link_offset_d) + 33'(joint_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			op_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 9; i++) rr_q[i] <= (i % 4 == 0) ? ONE_Q16 : '0;
			for (int i = 0; i < 3; i++) rt_q[i] <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						start_q <= 1'b1;
						state_q <= ST_CORT;
					end
				end
				ST_CORT: begin
					if (cor_done) begin
						start_q <= 1'b1;
						state_q <= ST_CORA;
					end
				end
				ST_CORA: begin
					if (cor_done) begin
						op_q <= '0;
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: state_q <= ST_LACC;
				ST_LACC: begin
					// advance link products, then the 3x4 product
					if (op_q == 3'd5) begin
						r_q <= '0;
						c_q <= '0;
						k_q <= '0;
						state_q <= ST_MMUL;
					end else begin
						op_q <= op_q + 3'd1;
						state_q <= ST_LMUL;
					end
				end
				ST_MMUL: state_q <= ST_MACC;
				ST_MACC: begin
					state_q <= ST_MMUL;
					if (k_q != 2'd2) begin
						k_q <= k_q + 2'd1;
					end else begin
						k_q <= '0;
						if (c_q != 2'd3) begin
							c_q <= c_q + 2'd1;
						end else begin
							c_q <= '0;
							if (r_q != 2'd2) begin
								r_q <= r_q + 2'd1;
							end else begin
								row_q <= '0;
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (row_q == 2'd2) begin
							// commit the new frame, or drop back to identity
							for (int i = 0; i < 9; i++)
								rr_q[i] <= last_q ? ((i % 4 == 0) ? ONE_Q16 : '0) : nr_q[i];
							for (int i = 0; i < 3; i++)
								rt_q[i] <= last_q ? '0 : nt_q[i];
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			a_q <= link_length_a;
			alpha_q <= link_twist_alpha;
			last_q <= last_joint;
			if (is_prismatic) begin
				d_q <= sat32(38'(dsum_w));
				theta_q <= link_angle_theta;
			end else begin
				d_q <= link_offset_d;
				theta_q <= link_angle_theta + joint_value[15:0];
			end
		end
		if (state_q == ST_CORT && cor_done) begin
			ct_q <= cor_cos;
			st_q <= cor_sin;
		end
		if (state_q == ST_CORA && cor_done) begin
			ca_q <= cor_cos;
			sa_q <= cor_sin;
		end
		if (state_q == ST_LMUL || state_q == ST_MMUL)
			prod_q <= prod_t'(opa_w) * prod_t'(opb_w);
		if (state_q == ST_LACC) begin
			case (op_q)
				3'd0: rel1_q <= -rnd_w[17:0];
				3'd1: rel2_q <= rnd_w[17:0];
				3'd2: rel4_q <= rnd_w[17:0];
				3'd3: rel5_q <= -rnd_w[17:0];
				3'd4: p0_q <= rnd_w[32:0];
				default: p1_q <= rnd_w[32:0];
			endcase
		end
		if (state_q == ST_MACC) begin
			acc_q <= acc_w;
			if (k_q == 2'd2) begin
				if (c_q == 2'd3)
					nt_q[r_q] <= sat32(38'(rnd_w) + 38'(rt_q[r_q]));
				else
					nr_q[ro_w] <= sat18(38'(rnd_w));
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign row_index = row_q;
	assign rot_col0 = nr_q[4'(row_q) * 4'd3];
	assign rot_col1 = nr_q[4'(row_q) * 4'd3 + 4'd1];
	assign rot_col2 = nr_q[4'(row_q) * 4'd3 + 4'd2];
	assign translation = nt_q[row_q];
	assign last_row = (row_q == 2'd2);
	assign end_of_chain = last_q;

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CORT && start_q))
		else $error("joint accepted without starting cordic");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_q != 2'd3) else $error("row index out of range");
	a_last_return: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && row_q == 2'd2) |=> in_ready)
		else $error("not idle after last row");
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while rows pending");

endmodule
